### src/pqrdp_pkg.sv
// ----------------------------------------------------------------------------
// pqrdp_pkg
// Shared types, codes and helpers for the PIR query row dot product block.
// ----------------------------------------------------------------------------
package pqrdp_pkg;

  // Query store geometry (fixed by the 10-bit query index)
  localparam int QDEPTH = 1024;
  localparam int QAW    = 10;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  // Modulus width at reset
  localparam logic [5:0] MOD_BITS_RST = 6'd32;

  // One database beat handed from front to back
  typedef struct packed {
    logic signed [7:0] db_byte;
    logic              row_end;
    logic              in_range;
    logic [31:0]       word;
  } work_t;

  // Mask for the modulus 2^bits; 0 acts as 1, 32 and up as 32
  function automatic logic [31:0] answer_mask(input logic [5:0] bits);
    logic [31:0] m;
    begin
      if (bits >= 6'd32) begin
        m = 32'hFFFF_FFFF;
      end else if (bits == 6'd0) begin
        m = 32'h0000_0001;
      end else begin
        m = (32'h0000_0001 << bits[4:0]) - 32'h0000_0001;
      end
      return m;
    end
  endfunction

endpackage

### src/pqrdp_if.sv
// ----------------------------------------------------------------------------
// pqrdp_if
// Valid/ready channel interfaces: input items, results and configuration.
// ----------------------------------------------------------------------------
interface pqrdp_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [9:0]        query_index;
  logic [31:0]       query_value;
  logic signed [7:0] db_byte;
  logic              row_end;

  modport source (output valid, operation, query_index, query_value, db_byte, row_end,
                  input ready);
  modport sink   (input valid, operation, query_index, query_value, db_byte, row_end,
                  output ready);
endinterface

interface pqrdp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] row_number;
  logic [31:0] answer_word;
  logic        too_many_columns;

  modport source (output valid, row_number, answer_word, too_many_columns, input ready);
  modport sink   (input valid, row_number, answer_word, too_many_columns, output ready);
endinterface

interface pqrdp_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] modulus_bits;

  modport source (output valid, modulus_bits, input ready);
  modport sink   (input valid, modulus_bits, output ready);
endinterface

### src/pqrdp_front.sv
// ----------------------------------------------------------------------------
// pqrdp_front
// Accepts input beats, writes query words, tracks the column and reads the
// query word for each database byte; hands database beats to the queue.
// ----------------------------------------------------------------------------
module pqrdp_front #(
  parameter int COLS = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pqrdp_in_if.sink             in_ch,
  output logic                 push,
  output pqrdp_pkg::work_t     push_data,
  input  logic                 q_full
);

  localparam int CW = $clog2(COLS + 1);

  logic [31:0]           qmem [pqrdp_pkg::QDEPTH];
  logic [CW-1:0]         col_r, col_nxt;
  logic [CW+pqrdp_pkg::QAW-1:0] col_ext;
  logic [pqrdp_pkg::QAW-1:0]    rd_addr;
  logic                  in_range;
  logic                  acc_load, acc_byte;

  logic                  s1_valid_r, s1_valid_nxt;
  logic signed [7:0]     s1_byte_r;
  logic                  s1_end_r;
  logic                  s1_inr_r;
  logic [31:0]           rd_word_r;

  // Handshake: stage one frees when its beat moves into the queue
  assign in_ch.ready = !s1_valid_r || !q_full;
  assign acc_load = in_ch.valid && in_ch.ready && (in_ch.operation == pqrdp_pkg::OP_LOAD);
  assign acc_byte = in_ch.valid && in_ch.ready && (in_ch.operation == pqrdp_pkg::OP_BYTE);
  assign push     = s1_valid_r && !q_full;

  // Column index into the store, modulo its depth
  assign col_ext  = {{pqrdp_pkg::QAW{1'b0}}, col_r};
  assign rd_addr  = col_ext[pqrdp_pkg::QAW-1:0];
  assign in_range = (32'(col_r) < 32'(COLS));

  // Column counter: saturates at COLS, clears at end of row
  always_comb begin
    col_nxt = col_r;
    if (acc_byte) begin
      if (in_ch.row_end) begin
        col_nxt = '0;
      end else if (in_range) begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (push) s1_valid_nxt = 1'b0;
    if (acc_byte) s1_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Query store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (acc_load) begin
      qmem[in_ch.query_index] <= in_ch.query_value;
    end
    if (acc_byte) begin
      rd_word_r <= qmem[rd_addr];
    end
  end

  // Stage one payload
  always_ff @(posedge clk) begin
    if (acc_byte) begin
      s1_byte_r <= in_ch.db_byte;
      s1_end_r  <= in_ch.row_end;
      s1_inr_r  <= in_range;
    end
  end

  assign push_data.db_byte  = s1_byte_r;
  assign push_data.row_end  = s1_end_r;
  assign push_data.in_range = s1_inr_r;
  assign push_data.word     = rd_word_r;

endmodule

### src/pqrdp_queue.sv
// ----------------------------------------------------------------------------
// pqrdp_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module pqrdp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pqrdp_pkg::work_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output pqrdp_pkg::work_t pop_data
);

  pqrdp_pkg::work_t ent_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = ent_r[rp_r];

  // Occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_data;
  end

endmodule

### src/pqrdp_back.sv
// ----------------------------------------------------------------------------
// pqrdp_back
// Multiplies each byte by its query word, accumulates the row and emits the
// masked row sum on end of row through an output register.
// ----------------------------------------------------------------------------
module pqrdp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [5:0]       modulus_bits,
  input  logic             q_not_empty,
  input  pqrdp_pkg::work_t q_data,
  output logic             pop,
  pqrdp_out_if.source      out_ch
);

  logic [31:0] sext;
  logic [31:0] prod_nxt;

  // Product stage
  logic        p_valid_r, p_valid_nxt;
  logic [31:0] p_prod_r;
  logic        p_end_r;
  logic        p_inr_r;

  // Row state
  logic [31:0] acc_r, acc_nxt;
  logic        ovf_r, ovf_nxt;
  logic [15:0] row_r;
  logic [31:0] sum;
  logic        adv;

  // Output register
  logic        o_valid_r, o_valid_nxt;
  logic [15:0] o_row_r;
  logic [31:0] o_ans_r;
  logic        o_tmc_r;

  // Accumulate stage moves unless a finished row meets a full output register
  assign adv = p_valid_r && (!p_end_r || !o_valid_r || out_ch.ready);
  assign pop = q_not_empty && (!p_valid_r || adv);

  // Low 32 bits of the signed product
  assign sext     = {{24{q_data.db_byte[7]}}, q_data.db_byte};
  assign prod_nxt = sext * q_data.word;

  assign sum = acc_r + (p_inr_r ? p_prod_r : 32'h0);

  always_comb begin
    p_valid_nxt = p_valid_r;
    if (adv) p_valid_nxt = 1'b0;
    if (pop) p_valid_nxt = 1'b1;
  end

  // Row accumulation and close
  always_comb begin
    acc_nxt = acc_r;
    ovf_nxt = ovf_r;
    if (adv) begin
      if (p_end_r) begin
        acc_nxt = 32'h0;
        ovf_nxt = 1'b0;
      end else begin
        acc_nxt = sum;
        ovf_nxt = ovf_r | !p_inr_r;
      end
    end
  end

  always_comb begin
    o_valid_nxt = o_valid_r;
    if (out_ch.ready) o_valid_nxt = 1'b0;
    if (adv && p_end_r) o_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      acc_r     <= 32'h0;
      ovf_r     <= 1'b0;
      row_r     <= 16'h0;
      o_valid_r <= 1'b0;
    end else begin
      p_valid_r <= p_valid_nxt;
      acc_r     <= acc_nxt;
      ovf_r     <= ovf_nxt;
      o_valid_r <= o_valid_nxt;
      if (adv && p_end_r) row_r <= row_r + 16'h1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      p_prod_r <= prod_nxt;
      p_end_r  <= q_data.row_end;
      p_inr_r  <= q_data.in_range;
    end
    if (adv && p_end_r) begin
      o_row_r <= row_r;
      o_ans_r <= sum & pqrdp_pkg::answer_mask(modulus_bits);
      o_tmc_r <= ovf_r | !p_inr_r;
    end
  end

  assign out_ch.valid            = o_valid_r;
  assign out_ch.row_number       = o_row_r;
  assign out_ch.answer_word      = o_ans_r;
  assign out_ch.too_many_columns = o_tmc_r;

endmodule

### src/pir_query_row_dot_product.sv
// ----------------------------------------------------------------------------
// pir_query_row_dot_product
// Server answer for lattice PIR: signed byte rows dotted with a query vector.
// ----------------------------------------------------------------------------
// The block takes one beat per cycle, query loads and database bytes alike,
// with no gaps at row boundaries while results are taken. A query word loaded
// in one cycle can be used by a database byte in the very next cycle. The byte
// that ends a row goes through store read, queue, multiply, then the accumulate
// into the output register. The sustained rate is set by the single 32x32
// multiplier and the one-port-read query store, each used once per byte. The
// modulus width may be written only while no beat is in flight.
module pir_query_row_dot_product #(
  parameter int COLS = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  pqrdp_in_if.sink     in_ch,
  pqrdp_out_if.source  out_ch,
  pqrdp_cfg_if.sink    cfg_ch
);

  logic             push, q_full, pop, q_not_empty;
  pqrdp_pkg::work_t push_data, q_data;
  logic [5:0]       mod_bits_r;

  // Configuration register: always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_bits_r <= pqrdp_pkg::MOD_BITS_RST;
    end else if (cfg_ch.valid) begin
      mod_bits_r <= cfg_ch.modulus_bits;
    end
  end

  // Front: accept, store queries, read the column's word
  pqrdp_front #(.COLS(COLS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // Decoupling queue
  pqrdp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  // Back: multiply, accumulate, emit
  pqrdp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .modulus_bits (mod_bits_r),
    .q_not_empty  (q_not_empty),
    .q_data       (q_data),
    .pop          (pop),
    .out_ch       (out_ch)
  );

endmodule

### test/pqrdp_row_sum_checker.sv
// ----------------------------------------------------------------------------
// pqrdp_row_sum_checker
// Watches the input, result and modulus channels of the PIR row dot product
// block, predicts every row answer from the beats it sees accepted, and
// compares each accepted result beat with the oldest answer still due.
// ----------------------------------------------------------------------------
module pqrdp_row_sum_checker #(
  parameter int COLS = 1024
) (
  input  logic  clk,
  input  logic  rst_n,
  pqrdp_in_if   in_ch,
  pqrdp_out_if  out_ch,
  pqrdp_cfg_if  cfg_ch,
  output int    mismatches,
  output int    awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] row_number;
    logic [31:0] answer_word;
    logic        too_many_columns;
  } row_answer_t;

  // Predicted block state
  logic [31:0] query_words [pqrdp_pkg::QDEPTH];
  logic [31:0] row_sum;
  int          row_cols;
  logic        row_ovf;
  logic [15:0] row_index;
  logic [5:0]  mod_bits;

  row_answer_t rows_due [$];
  row_answer_t want;
  row_answer_t got;
  logic [31:0] term;

  // Low modulus_bits bits set; 0 behaves as 1, anything above 32 as 32
  function automatic logic [31:0] modulus_mask(input logic [5:0] bits);
    int eff;
    eff = int'(bits);
    if (eff < 1) eff = 1;
    if (eff > 32) eff = 32;
    return 32'((64'd1 << eff) - 64'd1);
  endfunction

  initial begin
    mismatches = 0;
    awaiting   = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      row_sum    = '0;
      row_cols   = 0;
      row_ovf    = 1'b0;
      row_index  = '0;
      mod_bits   = pqrdp_pkg::MOD_BITS_RST;
      mismatches = 0;
      rows_due.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        mod_bits = cfg_ch.modulus_bits;
      end

      // Result beat: compare with the oldest answer due
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.row_number, out_ch.answer_word, out_ch.too_many_columns};
        if (rows_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result: row %0d word %h overflow %0b",
                     got.row_number, got.answer_word, got.too_many_columns);
          end
          mismatches++;
        end else begin
          want = rows_due.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("mismatch: exp row %0d word %h ovf %0b, got row %0d word %h ovf %0b",
                       want.row_number, want.answer_word, want.too_many_columns,
                       got.row_number, got.answer_word, got.too_many_columns);
            end
            mismatches++;
          end
        end
      end

      // Input beat: update the predicted state
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == pqrdp_pkg::OP_LOAD) begin
          query_words[in_ch.query_index] = in_ch.query_value;
        end else begin
          // Bytes past COLS add nothing and only raise the overflow flag
          if (row_cols < COLS) begin
            term     = {{24{in_ch.db_byte[7]}}, in_ch.db_byte} *
                       query_words[row_cols % pqrdp_pkg::QDEPTH];
            row_sum  = row_sum + term;
            row_cols = row_cols + 1;
          end else begin
            row_ovf = 1'b1;
          end
          if (in_ch.row_end) begin
            rows_due.push_back('{row_index, row_sum & modulus_mask(mod_bits), row_ovf});
            row_sum   = '0;
            row_cols  = 0;
            row_ovf   = 1'b0;
            row_index = row_index + 16'd1;
          end
        end
      end
    end
    awaiting = rows_due.size();
  end

endmodule

### test/pir_query_row_dot_product_tb.sv
// ----------------------------------------------------------------------------
// pir_query_row_dot_product_tb
// Drives query loads, database bytes and modulus writes into the PIR row dot
// product block with random gaps and result back-pressure; the checker beside
// the block predicts and compares every row answer.
// ----------------------------------------------------------------------------
module pir_query_row_dot_product_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS        = 1024;
  localparam int SETTLE      = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_BEATS = 25;
  localparam int HOLD_ROWS   = 60;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  pqrdp_in_if  in_ch();
  pqrdp_out_if out_ch();
  pqrdp_cfg_if cfg_ch();

  int  mismatches;
  int  awaiting;
  int  cycle_count = 0;
  int  beats_sent  = 0;
  int  stim_col    = 0;
  bit  full_rate    = 1'b0;
  bit  hold_results = 1'b0;
  bit  query_loaded [pqrdp_pkg::QDEPTH];

  logic [5:0] mod_plan [10] = '{6'd31, 6'd2, 6'd33, 6'd16, 6'd32,
                                6'd0, 6'd1, 6'd63, 6'd8, 6'd20};

  pir_query_row_dot_product #(.COLS(COLS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pqrdp_row_sum_checker #(.COLS(COLS)) row_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (full_rate || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result ready: random on/off runs, a long hold on request
  int ready_on  = 0;
  int ready_off = 0;
  int hold_left = 0;
  initial begin : result_ready_gen
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_ch.ready <= 1'b0;
        hold_left++;
        if (hold_left == HOLD_CYCLES) begin
          hold_left    = 0;
          hold_results = 1'b0;
        end
      end else if (full_rate) begin
        out_ch.ready <= 1'b1;
      end else if (ready_off > 0) begin
        out_ch.ready <= 1'b0;
        ready_off--;
      end else begin
        out_ch.ready <= 1'b1;
        if (ready_on > 0) begin
          ready_on--;
        end else begin
          ready_on  = $urandom_range(1, 30);
          ready_off = pick_gap();
        end
      end
    end
  end

  // One input beat; returns at the falling edge after acceptance
  task automatic send_beat(input logic op, input logic [9:0] idx, input logic [31:0] val,
                           input logic [7:0] data, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.query_index <= idx;
    in_ch.query_value <= val;
    in_ch.db_byte     <= data;
    in_ch.row_end     <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  // Query load with junk in the fields a load ignores
  task automatic load_word(input logic [9:0] idx, input logic [31:0] val);
    send_beat(pqrdp_pkg::OP_LOAD, idx, val, 8'($urandom), 1'($urandom));
    query_loaded[idx] = 1'b1;
  endtask

  // Database byte; the column about to be read is loaded first if still empty
  task automatic send_byte(input logic [7:0] data, input logic last);
    if (stim_col < COLS && !query_loaded[stim_col % pqrdp_pkg::QDEPTH]) begin
      load_word(10'(stim_col % pqrdp_pkg::QDEPTH), $urandom());
    end
    send_beat(pqrdp_pkg::OP_BYTE, 10'($urandom), $urandom(), data, last);
    if (last) stim_col = 0;
    else if (stim_col < COLS) stim_col++;
  endtask

  // Row of random bytes, short as a rule, with stray loads mixed in
  task automatic random_row();
    int len;
    len = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 12) : $urandom_range(13, 80);
    for (int c = 0; c < len; c++) begin
      if ($urandom_range(0, 99) < 12) begin
        if ($urandom_range(0, 99) < 70) load_word(10'($urandom_range(0, 15)), $urandom());
        else load_word(10'($urandom_range(0, pqrdp_pkg::QDEPTH - 1)), $urandom());
      end
      send_byte(8'($urandom), c == len - 1);
    end
  endtask

  task automatic write_modulus(input logic [5:0] bits);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.modulus_bits <= bits;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stop sending until every answer has come and the pipeline is empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin : stimulus
    int phase_start;
    in_ch.valid         = 1'b0;
    in_ch.operation     = pqrdp_pkg::OP_LOAD;
    in_ch.query_index   = '0;
    in_ch.query_value   = '0;
    in_ch.db_byte       = '0;
    in_ch.row_end       = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.modulus_bits = pqrdp_pkg::MOD_BITS_RST;
    for (int i = 0; i < pqrdp_pkg::QDEPTH; i++) query_loaded[i] = 1'b0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extreme query words and bytes at the reset modulus
    load_word(10'd0, 32'hFFFF_FFFF);
    load_word(10'd1, 32'h8000_0000);
    load_word(10'd2, 32'h0000_0000);
    load_word(10'd3, 32'h0000_0001);
    load_word(10'd4, 32'h7FFF_FFFF);
    load_word(10'd1023, $urandom());
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Modulus 0 behaves as 1, above 32 as 32
    drain();
    write_modulus(6'd0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();
    write_modulus(6'd63);
    send_byte(8'h80, 1'b1);
    drain();
    write_modulus(6'd1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h7F, 1'b1);

    // Random phases, one modulus setting each
    for (int p = 0; p < 10; p++) begin
      drain();
      write_modulus((p == 9) ? 6'($urandom) : mod_plan[p]);
      if (p == 2) begin
        // Results held off while single-byte rows keep coming
        hold_results = 1'b1;
        full_rate    = 1'b1;
        repeat (HOLD_ROWS) send_byte(8'($urandom), 1'b1);
        full_rate = 1'b0;
      end
      if (p == 4) begin
        // Whole query store, then a row that runs past the last column
        full_rate = 1'b1;
        for (int i = 0; i < pqrdp_pkg::QDEPTH; i++) load_word(10'(i), $urandom());
        for (int c = 0; c < COLS + 2; c++) send_byte(8'($urandom), c == COLS + 1);
      end
      full_rate   = (p == 3);
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) random_row();
      full_rate = 1'b0;
    end

    drain();
    if (mismatches == 0 && awaiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/pqrdp_pkg.sv
src/pqrdp_if.sv
src/pqrdp_front.sv
src/pqrdp_queue.sv
src/pqrdp_back.sv
src/pir_query_row_dot_product.sv
test/pqrdp_row_sum_checker.sv
test/pir_query_row_dot_product_tb.sv
